// ===== src/rhtc_pkg.sv =====
package rhtc_pkg;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned RATE_W = 15;
  localparam int unsigned TOL_W = 8;
  localparam int unsigned REASON_W = 3;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [0:0] OP_START = 1'b0;
  localparam logic [0:0] OP_TICK = 1'b1;

  localparam logic [REASON_W-1:0] REASON_RUNNING = 3'd0;
  localparam logic [REASON_W-1:0] REASON_NEAREST = 3'd1;
  localparam logic [REASON_W-1:0] REASON_EXACT = 3'd2;
  localparam logic [REASON_W-1:0] REASON_STALL = 3'd3;
  localparam logic [REASON_W-1:0] REASON_TOO_SMALL = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_TURN_RATE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_LINEAR = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXACT_TOL = 2'd2;

  localparam logic [RATE_W-1:0] TURN_RATE_RESET = 15'd546;
  localparam logic [TOL_W-1:0] EXACT_TOL_RESET = 8'd7;

  typedef struct packed {
    logic [RATE_W-1:0] turn_rate;
    logic              keep_linear;
    logic [TOL_W-1:0]  exact_tolerance;
  } cfg_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angular_command;
    logic                      linear_stop;
    logic                      finished;
    logic [REASON_W-1:0]       end_reason;
  } result_t;

endpackage

// ===== src/rhtc_core.sv =====
module rhtc_core #(
  parameter int unsigned REPORT_TICKS = 80,
  parameter int unsigned STALL_LIMIT = 3,
  parameter int unsigned COARSE_SHIFT = 7
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   advance,
  input  logic [0:0]                             opcode,
  input  logic signed [rhtc_pkg::ANGLE_W-1:0]    turn_angle,
  input  logic signed [rhtc_pkg::ANGLE_W-1:0]    yaw,
  input  rhtc_pkg::cfg_t                         cfg,
  output rhtc_pkg::result_t                      result
);
  import rhtc_pkg::*;

  localparam int unsigned TICK_W = $clog2(REPORT_TICKS + 2);
  localparam int unsigned STALL_W = $clog2(STALL_LIMIT + 1);
  localparam int unsigned COARSE_W = ANGLE_W - COARSE_SHIFT;

  logic [ANGLE_W-1:0]        target_yaw, target_yaw_next;
  logic signed [ANGLE_W-1:0] drive_command, drive_command_next;
  logic [ANGLE_W-1:0]        min_offset, min_offset_next;
  logic                      passed_nearest, passed_nearest_next;
  logic                      turning, turning_next;
  logic [TICK_W-1:0]         tick_count, tick_count_next;
  logic [COARSE_W-1:0]       last_coarse_yaw, last_coarse_yaw_next;
  logic [STALL_W-1:0]        stall_count, stall_count_next;

  logic [ANGLE_W-1:0]        angle_mag;
  logic [ANGLE_W+1:0]        angle_mag4;
  logic [ANGLE_W-1:0]        arc_diff;
  logic [ANGLE_W-1:0]        arc_mag;
  logic [ANGLE_W+1:0]        arc_mag4;
  logic [RATE_W+1:0]         rate3;
  logic [TICK_W-1:0]         tick_inc;
  logic [STALL_W-1:0]        stall_inc;
  logic [COARSE_W-1:0]       coarse;
  logic                      stall_end;
  logic                      exact_hit;
  logic                      in_window;
  logic signed [ANGLE_W-1:0] rate_cmd;

  always_comb begin
    angle_mag = turn_angle[ANGLE_W-1] ? (~turn_angle + 1'b1) : turn_angle;
    angle_mag4 = {angle_mag, 2'b00};
    arc_diff = target_yaw - yaw;
    arc_mag = arc_diff[ANGLE_W-1] ? (~arc_diff + 1'b1) : arc_diff;
    arc_mag4 = {arc_mag, 2'b00};
    rate3 = {2'b00, cfg.turn_rate} + {1'b0, cfg.turn_rate, 1'b0};
    rate_cmd = $signed({1'b0, cfg.turn_rate});
    tick_inc = tick_count + 1'b1;
    stall_inc = stall_count + 1'b1;
    coarse = yaw[ANGLE_W-1:COARSE_SHIFT];
    exact_hit = (arc_mag4 <= {3'b000, cfg.turn_rate})
                && (arc_mag <= {{(ANGLE_W-TOL_W){1'b0}}, cfg.exact_tolerance});
    in_window = arc_mag4 <= {1'b0, rate3};

    target_yaw_next = target_yaw;
    drive_command_next = drive_command;
    min_offset_next = min_offset;
    passed_nearest_next = passed_nearest;
    turning_next = turning;
    tick_count_next = tick_count;
    last_coarse_yaw_next = last_coarse_yaw;
    stall_count_next = stall_count;
    stall_end = 1'b0;
    result = '0;

    unique case (opcode)
      OP_START: begin
        if (angle_mag4 <= {3'b000, cfg.turn_rate}) begin
          turning_next = 1'b0;
          drive_command_next = '0;
          passed_nearest_next = 1'b0;
          result.finished = 1'b1;
          result.end_reason = REASON_TOO_SMALL;
        end else begin
          target_yaw_next = yaw + turn_angle;
          drive_command_next = turn_angle[ANGLE_W-1] ? -rate_cmd : rate_cmd;
          min_offset_next = '1;
          passed_nearest_next = 1'b0;
          turning_next = 1'b1;
          tick_count_next = '0;
          last_coarse_yaw_next = '0;
          stall_count_next = '0;
          result.angular_command = turn_angle[ANGLE_W-1] ? -rate_cmd : rate_cmd;
          result.linear_stop = ~cfg.keep_linear;
        end
      end
      OP_TICK: begin
        if (turning) begin
          result.linear_stop = ~cfg.keep_linear;
          if (tick_inc > TICK_W'(REPORT_TICKS)) begin
            tick_count_next = '0;
            last_coarse_yaw_next = coarse;
            if (coarse == last_coarse_yaw) begin
              stall_count_next = stall_inc;
              stall_end = stall_inc >= STALL_W'(STALL_LIMIT);
            end else begin
              stall_count_next = '0;
            end
          end else begin
            tick_count_next = tick_inc;
          end

          priority if (stall_end) begin
            result.end_reason = REASON_STALL;
          end else if (passed_nearest) begin
            result.end_reason = REASON_NEAREST;
          end else if (exact_hit) begin
            result.end_reason = REASON_EXACT;
          end else begin
            result.end_reason = REASON_RUNNING;
          end

          if (stall_end || passed_nearest || exact_hit) begin
            turning_next = 1'b0;
            drive_command_next = '0;
            passed_nearest_next = 1'b0;
            result.finished = 1'b1;
          end else begin
            if (in_window) begin
              if (arc_mag <= min_offset) begin
                min_offset_next = arc_mag;
              end else begin
                drive_command_next = -drive_command;
                passed_nearest_next = 1'b1;
              end
            end
            result.angular_command = drive_command_next;
          end
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_yaw <= '0;
      drive_command <= '0;
      min_offset <= '1;
      passed_nearest <= 1'b0;
      turning <= 1'b0;
      tick_count <= '0;
      last_coarse_yaw <= '0;
      stall_count <= '0;
    end else if (advance) begin
      target_yaw <= target_yaw_next;
      drive_command <= drive_command_next;
      min_offset <= min_offset_next;
      passed_nearest <= passed_nearest_next;
      turning <= turning_next;
      tick_count <= tick_count_next;
      last_coarse_yaw <= last_coarse_yaw_next;
      stall_count <= stall_count_next;
    end
  end

endmodule

// ===== src/relative_heading_turn_controller.sv =====
// Turns a robot in place by a relative angle in binary-angle units (65536 per turn).
// Input channel (in_valid/in_ready): opcode 0 starts a turn with turn_angle from the
// current yaw; opcode 1 is a yaw sample tick. Each input transaction yields exactly
// one output transaction (out_valid/out_ready) carrying angular_command,
// linear_stop, finished and end_reason.
// A transaction taken is registered in the input register, evaluated against the
// turn state, and its result is captured in the result register. While the receiver
// takes each result, a new transaction can be taken every cycle, so throughput is one
// item per cycle, set by the single evaluation pass between input and result registers.
// When the receiver holds out_ready low, the result register holds its value and
// the input register holds one more transaction; in_ready then falls until the
// result is taken.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once and are
// meant to happen only while no transaction is in flight.
// Reset restores turn_rate 546, keep_linear 0 and exact_tolerance 7, leaves the
// block idle with both pipeline registers empty, and accepts input on the next cycle.
module relative_heading_turn_controller #(
  parameter int unsigned REPORT_TICKS = 80,
  parameter int unsigned STALL_LIMIT = 3,
  parameter int unsigned COARSE_SHIFT = 7
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  logic [rhtc_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [rhtc_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [0:0]                               opcode,
  input  logic signed [rhtc_pkg::ANGLE_W-1:0]      turn_angle,
  input  logic signed [rhtc_pkg::ANGLE_W-1:0]      yaw,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [rhtc_pkg::ANGLE_W-1:0]      angular_command,
  output logic                                     linear_stop,
  output logic                                     finished,
  output logic [rhtc_pkg::REASON_W-1:0]            end_reason
);
  import rhtc_pkg::*;

  cfg_t                      cfg;
  logic                      hold_valid;
  logic [0:0]                hold_opcode;
  logic signed [ANGLE_W-1:0] hold_angle;
  logic signed [ANGLE_W-1:0] hold_yaw;
  logic                      advance;
  result_t                   result;

  assign advance = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.turn_rate <= TURN_RATE_RESET;
      cfg.keep_linear <= 1'b0;
      cfg.exact_tolerance <= EXACT_TOL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TURN_RATE: cfg.turn_rate <= cfg_data[RATE_W-1:0];
        CFG_KEEP_LINEAR: cfg.keep_linear <= cfg_data[0];
        CFG_EXACT_TOL: cfg.exact_tolerance <= cfg_data[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_opcode <= opcode;
      hold_angle <= turn_angle;
      hold_yaw <= yaw;
    end
  end

  rhtc_core #(
    .REPORT_TICKS(REPORT_TICKS),
    .STALL_LIMIT(STALL_LIMIT),
    .COARSE_SHIFT(COARSE_SHIFT)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .opcode(hold_opcode),
    .turn_angle(hold_angle),
    .yaw(hold_yaw),
    .cfg(cfg),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      angular_command <= result.angular_command;
      linear_stop <= result.linear_stop;
      finished <= result.finished;
      end_reason <= result.end_reason;
    end
  end

  assert property (@(posedge clk) disable iff (rst) advance |=> out_valid)
    else $error("Evaluated transaction did not reach the output register.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> angular_command == '0)
    else $error("Finished turn carries a nonzero command.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> finished == (end_reason != REASON_RUNNING))
    else $error("End reason disagrees with finished flag.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && end_reason == REASON_TOO_SMALL |-> !linear_stop)
    else $error("Rejected small turn forced a linear stop.");

endmodule

// ===== tb/tb_relative_heading_turn_controller.sv =====
module tb_relative_heading_turn_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import rhtc_pkg::*;

  localparam int unsigned REPORT_TICKS = 80;
  localparam int unsigned STALL_LIMIT = 3;
  localparam int unsigned COARSE_SHIFT = 7;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int unsigned PHASE_ITEMS = 245;
  localparam int unsigned CALM_FROM = 1000;
  localparam int unsigned CALM_TO = 1300;
  localparam int unsigned HOLD_AT = 600;
  localparam int unsigned HOLD_CYCLES = 100;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_CAP = 50;

  typedef struct packed {
    logic [0:0]                op;
    logic signed [ANGLE_W-1:0] angle;
    logic signed [ANGLE_W-1:0] yaw;
  } turn_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_TURN_RATE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [0:0] opcode = OP_START;
  logic signed [ANGLE_W-1:0] turn_angle = '0;
  logic signed [ANGLE_W-1:0] yaw = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ANGLE_W-1:0] angular_command;
  logic linear_stop;
  logic finished;
  logic [REASON_W-1:0] end_reason;

  turn_item_t turn_requests[$];
  result_t turn_responses[$];
  turn_item_t offered;
  result_t head_response;

  int unsigned queued_items = 0;
  int unsigned accepted_items = 0;
  int unsigned checked_results = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;

  logic [RATE_W-1:0] rate_cfg = TURN_RATE_RESET;
  logic keep_linear_cfg = 1'b0;
  logic [TOL_W-1:0] tolerance_cfg = EXACT_TOL_RESET;

  logic [ANGLE_W-1:0] goal_yaw = '0;
  int drive_rate = 0;
  int unsigned closest_arc = 16'hFFFF;
  bit overshot = 1'b0;
  bit turn_active = 1'b0;
  int unsigned sample_ticks = 0;
  logic [ANGLE_W-1:0] last_bucket = '0;
  int unsigned stall_hits = 0;

  relative_heading_turn_controller #(
    .REPORT_TICKS(REPORT_TICKS),
    .STALL_LIMIT(STALL_LIMIT),
    .COARSE_SHIFT(COARSE_SHIFT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .turn_angle(turn_angle),
    .yaw(yaw),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .angular_command(angular_command),
    .linear_stop(linear_stop),
    .finished(finished),
    .end_reason(end_reason)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void stop_turn();
    turn_active = 1'b0;
    drive_rate = 0;
    overshot = 1'b0;
  endfunction

  function automatic result_t predict_turn_response(turn_item_t item);
    result_t r;
    logic [ANGLE_W-1:0] ang_u;
    logic [ANGLE_W-1:0] yaw_u;
    logic [ANGLE_W-1:0] diff;
    logic [ANGLE_W-1:0] bucket;
    int unsigned mag;
    int unsigned arc;
    int unsigned rate_u;
    ang_u = item.angle;
    yaw_u = item.yaw;
    rate_u = rate_cfg;
    r = '0;
    if (item.op == OP_START) begin
      mag = ang_u[ANGLE_W-1] ? 32'h10000 - ang_u : ang_u;
      if (mag * 4 <= rate_u) begin
        stop_turn();
        r.finished = 1'b1;
        r.end_reason = REASON_TOO_SMALL;
        return r;
      end
      goal_yaw = yaw_u + ang_u;
      drive_rate = ang_u[ANGLE_W-1] ? -int'(rate_u) : int'(rate_u);
      closest_arc = 16'hFFFF;
      overshot = 1'b0;
      turn_active = 1'b1;
      sample_ticks = 0;
      last_bucket = '0;
      stall_hits = 0;
      r.angular_command = drive_rate[ANGLE_W-1:0];
      r.linear_stop = !keep_linear_cfg;
      return r;
    end
    if (!turn_active) begin
      return r;
    end
    r.linear_stop = !keep_linear_cfg;
    sample_ticks++;
    if (sample_ticks > REPORT_TICKS) begin
      bucket = yaw_u >> COARSE_SHIFT;
      sample_ticks = 0;
      if (bucket == last_bucket) begin
        stall_hits++;
        if (stall_hits >= STALL_LIMIT) begin
          stop_turn();
          r.finished = 1'b1;
          r.end_reason = REASON_STALL;
          return r;
        end
      end else begin
        stall_hits = 0;
      end
      last_bucket = bucket;
    end
    if (overshot) begin
      stop_turn();
      r.finished = 1'b1;
      r.end_reason = REASON_NEAREST;
      return r;
    end
    diff = goal_yaw - yaw_u;
    arc = diff[ANGLE_W-1] ? 32'h10000 - diff : diff;
    if (arc * 4 <= rate_u && arc <= tolerance_cfg) begin
      stop_turn();
      r.finished = 1'b1;
      r.end_reason = REASON_EXACT;
      return r;
    end
    if (arc * 4 <= 3 * rate_u) begin
      if (arc <= closest_arc) begin
        closest_arc = arc;
      end else begin
        drive_rate = -drive_rate;
        overshot = 1'b1;
      end
    end
    r.angular_command = drive_rate[ANGLE_W-1:0];
    return r;
  endfunction

  function automatic bit idle_now();
    bit calm;
    calm = accepted_items >= CALM_FROM && accepted_items < CALM_TO;
    return !calm && ($urandom_range(99) < 36);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] result %0d: %s got %0d expected %0d", $realtime, checked_results, what,
               got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        turn_responses.push_back(predict_turn_response(offered));
        accepted_items <= accepted_items + 1;
      end
      if (!in_valid || in_ready) begin
        if (turn_requests.size() != 0 && !idle_now()) begin
          offered = turn_requests.pop_front();
          in_valid <= 1'b1;
          opcode <= offered.op;
          turn_angle <= offered.angle;
          yaw <= offered.yaw;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (turn_responses.size() == 0) begin
          report_mismatch("unexpected transaction, angular_command", angular_command, 0);
        end else begin
          head_response = turn_responses.pop_front();
          if (angular_command !== head_response.angular_command) begin
            report_mismatch("angular_command", angular_command, head_response.angular_command);
          end
          if (linear_stop !== head_response.linear_stop) begin
            report_mismatch("linear_stop", linear_stop, head_response.linear_stop);
          end
          if (finished !== head_response.finished) begin
            report_mismatch("finished", finished, head_response.finished);
          end
          if (end_reason !== head_response.end_reason) begin
            report_mismatch("end_reason", end_reason, head_response.end_reason);
          end
        end
        checked_results <= checked_results + 1;
      end
      out_ready <= (hold_left == 0) && !idle_now();
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_items >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_item(logic [0:0] op, logic [ANGLE_W-1:0] angle_v,
                            logic [ANGLE_W-1:0] yaw_v);
    turn_item_t item;
    item.op = op;
    item.angle = angle_v;
    item.yaw = yaw_v;
    turn_requests.push_back(item);
    queued_items++;
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_TURN_RATE: rate_cfg = value[RATE_W-1:0];
      CFG_KEEP_LINEAR: keep_linear_cfg = value[0];
      CFG_EXACT_TOL: tolerance_cfg = value[TOL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_turn_config(logic [RATE_W-1:0] rate, logic keep, logic [TOL_W-1:0] tol);
    write_register(CFG_TURN_RATE, rate);
    write_register(CFG_KEEP_LINEAR, {14'($urandom), keep});
    write_register(CFG_EXACT_TOL, {7'($urandom), tol});
    write_register(CFG_UNUSED, 15'($urandom));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while (checked_results < queued_items) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_directed();
    queue_item(OP_TICK, 16'h7FFF, 16'h8000);
    queue_item(OP_START, 16'd0, 16'd0);
    queue_item(OP_START, 16'd136, 16'd100);
    queue_item(OP_START, -16'sd136, 16'd100);
    queue_item(OP_START, 16'd137, 16'd0);
    queue_item(OP_TICK, 16'd0, 16'd137);
    queue_item(OP_START, 16'h8000, 16'h7FFF);
    queue_item(OP_TICK, 16'hFFFF, 16'd6);
    queue_item(OP_START, 16'h7FFF, 16'h8000);
    queue_item(OP_TICK, 16'd0, -16'sd401);
    queue_item(OP_TICK, 16'd0, -16'sd9);
    queue_item(OP_TICK, 16'd0, 16'd99);
    queue_item(OP_TICK, 16'd0, 16'd99);
    queue_item(OP_START, 16'd1000, 16'd0);
    queue_item(OP_START, -16'sd2000, 16'd5);
    queue_item(OP_TICK, 16'd0, 16'd20000);
    queue_item(OP_START, 16'd10, 16'd0);
    queue_item(OP_TICK, 16'd0, 16'd0);
    queue_item(OP_START, -16'sd32767, 16'h7FFF);
    queue_item(OP_TICK, 16'h8000, 16'h7FFF);
    queue_item(OP_START, 16'd0, 16'h8000);
  endtask

  task automatic queue_approach();
    int unsigned rate_u;
    int unsigned lo;
    int unsigned hi;
    int unsigned mag;
    int unsigned steps;
    int unsigned last;
    int unsigned jit;
    int ang;
    int start;
    int y;
    rate_u = rate_cfg;
    lo = rate_u / 4 + 1;
    if (lo > 32767) lo = 32767;
    hi = rate_u * 4;
    if ($urandom_range(9) == 0) hi = 32767;
    if (hi > 32767) hi = 32767;
    if (hi < lo) hi = lo;
    mag = $urandom_range(hi, lo);
    ang = $urandom_range(1) ? -int'(mag) : int'(mag);
    start = $urandom_range(65535);
    steps = $urandom_range(24, 2);
    last = steps + $urandom_range(4);
    if ($urandom_range(7) == 0) last = $urandom_range(last, 0);
    jit = $urandom_range(3);
    queue_item(OP_START, 16'(ang), 16'(start));
    for (int k = 1; k <= int'(last); k++) begin
      y = start + (ang * k) / int'(steps) + int'($urandom_range(2 * jit)) - int'(jit);
      queue_item(OP_TICK, 16'($urandom), 16'(y));
    end
  endtask

  task automatic queue_stall();
    int unsigned rate_u;
    int unsigned lo;
    int unsigned mag;
    int unsigned ticks;
    int ang;
    logic [ANGLE_W-1:0] base;
    bit moved;
    rate_u = rate_cfg;
    lo = (3 * rate_u) / 4 + 400;
    if (lo > 32000) lo = 32000;
    mag = $urandom_range(32767, lo);
    ang = $urandom_range(1) ? -int'(mag) : int'(mag);
    base = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom) & 16'hFF80;
    ticks = $urandom_range(330, 250);
    moved = 1'b0;
    queue_item(OP_START, 16'(ang), base | 16'($urandom_range(127)));
    for (int k = 0; k < int'(ticks); k++) begin
      if (!moved && $urandom_range(199) == 0) begin
        base = base + 16'd128;
        moved = 1'b1;
      end
      queue_item(OP_TICK, 16'($urandom), base | 16'($urandom_range(127)));
    end
  endtask

  task automatic queue_noise();
    int unsigned count;
    count = $urandom_range(8, 1);
    repeat (count) begin
      queue_item(1'($urandom_range(1)), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic queue_random(int unsigned amount);
    int unsigned goal;
    int unsigned pick;
    goal = queued_items + amount;
    while (queued_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        queue_approach();
      end else if (pick < 72) begin
        queue_stall();
      end else begin
        queue_noise();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    queue_directed();
    queue_random(PHASE_ITEMS);
    drain();
    set_turn_config(15'd32767, 1'b1, 8'd255);
    queue_random(PHASE_ITEMS);
    drain();
    set_turn_config(15'd0, 1'b0, 8'd0);
    queue_random(PHASE_ITEMS);
    drain();
    set_turn_config(15'd1, 1'b1, 8'd0);
    queue_random(PHASE_ITEMS);
    drain();
    set_turn_config(15'd2000, 1'b0, 8'd255);
    queue_random(PHASE_ITEMS);
    drain();
    set_turn_config(15'($urandom_range(4000, 64)), 1'($urandom_range(1)),
                    8'($urandom_range(255)));
    queue_random(PHASE_ITEMS);
    drain();
    set_turn_config(15'd300, 1'b1, 8'd40);
    queue_random(PHASE_ITEMS);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rhtc_pkg.sv
src/rhtc_core.sv
src/relative_heading_turn_controller.sv
tb/tb_relative_heading_turn_controller.sv
